### rtl/phfu_pkg.sv
// ----------------------------------------------------------------------------
// phfu_pkg
// Shared types, constants and decode helpers for the hazard/forwarding unit.
// ----------------------------------------------------------------------------
`default_nettype none

package phfu_pkg;

    localparam int REG_INDEX_BITS = 5;
    localparam int CLASS_BITS     = 3;
    localparam int FLAG_BITS      = 2;

    typedef logic [REG_INDEX_BITS-1:0] t_reg_idx;
    typedef logic [FLAG_BITS-1:0]      t_dest_flags;

    // Flag bit positions inside a dest_flags field
    localparam int FLAG_WRITE = 0;
    localparam int FLAG_LOAD  = 1;

    typedef enum logic [CLASS_BITS-1:0] {
        CL_RTYPE = 3'd0,   // reads rs, rt
        CL_SHIFT = 3'd1,   // reads rt
        CL_JR    = 3'd2,   // reads rs in decode
        CL_IMM   = 3'd3,   // immediate or load, reads rs
        CL_STORE = 3'd4,   // reads rs, rt
        CL_BEQ   = 3'd5,   // BEQ/BNE, reads rs, rt in decode
        CL_BGTZ  = 3'd6,   // reads rs in decode
        CL_NONE  = 3'd7    // reads nothing
    } t_iclass;

    typedef struct packed {
        logic rd_t;
        logic rd_s;
    } t_reads;

    typedef struct packed {
        t_iclass     id_class;
        t_reg_idx    id_src_s;
        t_reg_idx    id_src_t;
        t_iclass     ex_class;
        t_reg_idx    ex_src_s;
        t_reg_idx    ex_src_t;
        t_dest_flags ex_dest_flags;
        t_reg_idx    ex_dest;
        logic        ex_flush;
        t_dest_flags dm_dest_flags;
        t_reg_idx    dm_dest;
    } t_in_item;

    typedef struct packed {
        logic stall_res;
        logic fwd_s_to_decode;
        logic fwd_t_to_decode;
        logic fwd_s_to_execute;
        logic fwd_t_to_execute;
    } t_out_item;

    // Source operands read by each instruction class
    function automatic t_reads class_reads(input t_iclass cls);
        t_reads r;
        case (cls)
            CL_RTYPE: r = '{rd_t: 1'b1, rd_s: 1'b1};
            CL_SHIFT: r = '{rd_t: 1'b1, rd_s: 1'b0};
            CL_JR:    r = '{rd_t: 1'b0, rd_s: 1'b1};
            CL_IMM:   r = '{rd_t: 1'b0, rd_s: 1'b1};
            CL_STORE: r = '{rd_t: 1'b1, rd_s: 1'b1};
            CL_BEQ:   r = '{rd_t: 1'b1, rd_s: 1'b1};
            CL_BGTZ:  r = '{rd_t: 1'b0, rd_s: 1'b1};
            default:  r = '{rd_t: 1'b0, rd_s: 1'b0};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/phfu_if.sv
// ----------------------------------------------------------------------------
// phfu_in_if / phfu_out_if
// Valid/ready channels carrying a pipeline snapshot and its hazard result.
// ----------------------------------------------------------------------------
`default_nettype none

interface phfu_in_if;
    logic                 valid;
    logic                 ready;
    logic [phfu_pkg::CLASS_BITS-1:0] id_class;
    phfu_pkg::t_reg_idx    id_src_s;
    phfu_pkg::t_reg_idx    id_src_t;
    logic [phfu_pkg::CLASS_BITS-1:0] ex_class;
    phfu_pkg::t_reg_idx    ex_src_s;
    phfu_pkg::t_reg_idx    ex_src_t;
    phfu_pkg::t_dest_flags ex_dest_flags;
    phfu_pkg::t_reg_idx    ex_dest;
    logic                 ex_flush;
    phfu_pkg::t_dest_flags dm_dest_flags;
    phfu_pkg::t_reg_idx    dm_dest;

    modport source (
        output valid, id_class, id_src_s, id_src_t, ex_class, ex_src_s, ex_src_t,
               ex_dest_flags, ex_dest, ex_flush, dm_dest_flags, dm_dest,
        input  ready
    );
    modport sink (
        input  valid, id_class, id_src_s, id_src_t, ex_class, ex_src_s, ex_src_t,
               ex_dest_flags, ex_dest, ex_flush, dm_dest_flags, dm_dest,
        output ready
    );
endinterface

interface phfu_out_if;
    logic valid;
    logic ready;
    logic stall_res;
    logic fwd_s_to_decode;
    logic fwd_t_to_decode;
    logic fwd_s_to_execute;
    logic fwd_t_to_execute;

    modport source (
        output valid, stall_res, fwd_s_to_decode, fwd_t_to_decode,
               fwd_s_to_execute, fwd_t_to_execute,
        input  ready
    );
    modport sink (
        input  valid, stall_res, fwd_s_to_decode, fwd_t_to_decode,
               fwd_s_to_execute, fwd_t_to_execute,
        output ready
    );
endinterface

`default_nettype wire

### rtl/pipeline_hazard_forward_unit.sv
// ----------------------------------------------------------------------------
// pipeline_hazard_forward_unit
// Stall and forwarding decisions for a five-stage pipeline snapshot.
// ----------------------------------------------------------------------------
//  Channel  Dir  Port    Payload
//  -------  ---  ------  ------------------------------------------------------
//  in       in   i_in    decode/execute/memory stage snapshot (11 fields)
//  out      out  o_out   stall_res and four forwarding flags
//
//  The path runs through the input register, compare logic and the result register.
//  One item per cycle sustained while o_out is not stalled; the register index compares set the path.
//  Reset (i_rst_n low, synchronous) empties both registers.
//  A stall on o_out holds the result; i_in keeps accepting while the input
//  register can move on or is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module pipeline_hazard_forward_unit (
    input  wire           i_clk,
    input  wire           i_rst_n,
    phfu_in_if.sink       i_in,
    phfu_out_if.source    o_out
);

    logic                 r_in_vld;
    phfu_pkg::t_in_item   r_in;
    logic                 r_out_vld;
    phfu_pkg::t_out_item  r_out;
    phfu_pkg::t_out_item  n_out;

    logic                 out_free;
    logic                 in_take;
    logic                 move;

    assign out_free = !r_out_vld || o_out.ready;
    assign move     = r_in_vld && out_free;
    assign in_take  = i_in.valid && i_in.ready;

    assign i_in.ready = !r_in_vld || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (move) begin
                r_in_vld <= 1'b0;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.id_class      <= phfu_pkg::t_iclass'(i_in.id_class);
            r_in.id_src_s      <= i_in.id_src_s;
            r_in.id_src_t      <= i_in.id_src_t;
            r_in.ex_class      <= phfu_pkg::t_iclass'(i_in.ex_class);
            r_in.ex_src_s      <= i_in.ex_src_s;
            r_in.ex_src_t      <= i_in.ex_src_t;
            r_in.ex_dest_flags <= i_in.ex_dest_flags;
            r_in.ex_dest       <= i_in.ex_dest;
            r_in.ex_flush      <= i_in.ex_flush;
            r_in.dm_dest_flags <= i_in.dm_dest_flags;
            r_in.dm_dest       <= i_in.dm_dest;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    // Hazard and forwarding logic
    logic              ex_w, ex_l, dm_w, dm_l;
    logic              ex_s, ex_t, dm_s, dm_t;
    logic              in_decode, ex_in_exec;
    logic              stall;
    phfu_pkg::t_reads  id_rd, ex_rd;

    always_comb begin
        ex_w = r_in.ex_dest_flags[phfu_pkg::FLAG_WRITE] && (r_in.ex_dest != '0);
        ex_l = r_in.ex_dest_flags[phfu_pkg::FLAG_LOAD]  && (r_in.ex_dest != '0);
        dm_w = r_in.dm_dest_flags[phfu_pkg::FLAG_WRITE] && (r_in.dm_dest != '0);
        dm_l = r_in.dm_dest_flags[phfu_pkg::FLAG_LOAD]  && (r_in.dm_dest != '0);

        id_rd = phfu_pkg::class_reads(r_in.id_class);
        ex_rd = phfu_pkg::class_reads(r_in.ex_class);

        in_decode  = r_in.id_class inside {phfu_pkg::CL_JR, phfu_pkg::CL_BEQ,
                                           phfu_pkg::CL_BGTZ};
        ex_in_exec = r_in.ex_class inside {phfu_pkg::CL_RTYPE, phfu_pkg::CL_SHIFT,
                                           phfu_pkg::CL_IMM, phfu_pkg::CL_STORE};

        ex_s = r_in.ex_dest == r_in.id_src_s;
        ex_t = r_in.ex_dest == r_in.id_src_t;
        dm_s = r_in.dm_dest == r_in.id_src_s;
        dm_t = r_in.dm_dest == r_in.id_src_t;

        stall = 1'b0;
        if (!in_decode) begin
            // younger execute-stage writer overrides the memory stage
            if (id_rd.rd_s && (dm_w || dm_l) && dm_s && !(ex_w && ex_s)) stall = 1'b1;
            if (id_rd.rd_t && (dm_w || dm_l) && dm_t && !(ex_w && ex_t)) stall = 1'b1;
        end else begin
            if (id_rd.rd_s && ex_w && ex_s) stall = 1'b1;
            if (id_rd.rd_t && ex_w && ex_t) stall = 1'b1;
            if (id_rd.rd_s && dm_l && dm_s) stall = 1'b1;
            if (id_rd.rd_t && dm_l && dm_t) stall = 1'b1;
        end
        if (id_rd.rd_s && ex_l && ex_s) stall = 1'b1;
        if (id_rd.rd_t && ex_l && ex_t) stall = 1'b1;

        n_out.stall_res        = stall && !r_in.ex_flush;
        n_out.fwd_s_to_decode  = in_decode && id_rd.rd_s && dm_w && dm_s;
        n_out.fwd_t_to_decode  = in_decode && id_rd.rd_t && dm_w && dm_t;
        n_out.fwd_s_to_execute = ex_in_exec && ex_rd.rd_s && dm_w
                                 && (r_in.dm_dest == r_in.ex_src_s);
        n_out.fwd_t_to_execute = ex_in_exec && ex_rd.rd_t && dm_w
                                 && (r_in.dm_dest == r_in.ex_src_t);
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.stall_res        = r_out.stall_res;
    assign o_out.fwd_s_to_decode  = r_out.fwd_s_to_decode;
    assign o_out.fwd_t_to_decode  = r_out.fwd_t_to_decode;
    assign o_out.fwd_s_to_execute = r_out.fwd_s_to_execute;
    assign o_out.fwd_t_to_execute = r_out.fwd_t_to_execute;

endmodule

`default_nettype wire

### rtl/phfu_checker.sv
// ----------------------------------------------------------------------------
// phfu_checker
// Port-level checks of flow through the hazard/forwarding unit.
// ----------------------------------------------------------------------------
`default_nettype none

module phfu_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_out_valid,
    input wire i_out_ready
);

    // A pending result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Empty output side means the input side is open
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // Input only blocks under output backpressure
    a_block_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input blocked without output stall");

    // An accepted item reaches the output once the output side has room
    a_item_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 (!i_out_valid || i_out_ready) |=> i_out_valid)
        else $error("accepted item did not advance");

endmodule

bind pipeline_hazard_forward_unit phfu_checker u_phfu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);

`default_nettype wire
